// ----- hdl/sorted_priority_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Clocked checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared constants and types of the sorted priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     pop_valid;
    logic                     empty_error;
    logic                     full_drop;
    logic [4:0]               entry_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] head_value;
  } out_item_t;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]        raddr;
  } ram_req_t;

endpackage

`default_nettype wire

// ----- hdl/spq_ram.sv -----
// ----------------------------------------------------------------------------
// spq_ram
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram import spq_pkg::*; (
  input  wire logic                     clk,
  input  wire ram_req_t                 req,
  output logic signed [DATA_W-1:0]      rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- hdl/spq_seq.sv -----
// ----------------------------------------------------------------------------
// spq_seq
// Sequencer that shifts entries through the store with one shared comparator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_priority_queue_assert.svh"

module spq_seq import spq_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire in_item_t                item,
  input  wire logic                    ack,
  output logic                         idle,
  output logic                         done,
  output out_item_t                    result,
  output ram_req_t                     ram_req,
  input  wire logic signed [DATA_W-1:0] ram_rdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [DATA_W-1:0] head_r, head_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     is_ins_r, is_ins_nxt;
  logic signed [DATA_W-1:0] popped_r, popped_nxt;
  logic                     pop_valid_r, pop_valid_nxt;
  logic                     empty_err_r, empty_err_nxt;
  logic                     full_drop_r, full_drop_nxt;

  logic [CNT_W-1:0] idx_m1;
  logic [CNT_W-1:0] idx_p1;
  logic             less;

  logic flag_clash;
  logic ins_shift;
  logic ins_count_ok;

  assign idx_m1 = idx_r - CNT_ONE;
  assign idx_p1 = idx_r + CNT_ONE;
  // The single comparator of the block.
  assign less   = ram_rdata < val_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    val_nxt       = val_r;
    is_ins_nxt    = is_ins_r;
    popped_nxt    = popped_r;
    pop_valid_nxt = pop_valid_r;
    empty_err_nxt = empty_err_r;
    full_drop_nxt = full_drop_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = idx_r[ADDR_W-1:0];
    ram_req.wdata = val_r;
    ram_req.raddr = is_ins_r ? idx_m1[ADDR_W-1:0] : idx_r[ADDR_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt       = item.value;
          popped_nxt    = '0;
          pop_valid_nxt = 1'b0;
          empty_err_nxt = 1'b0;
          full_drop_nxt = 1'b0;
          is_ins_nxt    = (item.mode == MODE_INSERT);
          state_nxt     = S_DONE;
          if (item.mode == MODE_INSERT) begin
            if (count_r == CNT_FULL) begin
              full_drop_nxt = 1'b1;
            end else if (count_r == '0) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = '0;
              ram_req.wdata = item.value;
              head_nxt      = item.value;
              count_nxt     = CNT_ONE;
            end else begin
              idx_nxt   = count_r;
              state_nxt = S_RD;
            end
          end else if (item.mode == MODE_POP) begin
            if (count_r == '0) begin
              empty_err_nxt = 1'b1;
            end else begin
              popped_nxt    = head_r;
              pop_valid_nxt = 1'b1;
              if (count_r == CNT_ONE) begin
                count_nxt = '0;
              end else begin
                idx_nxt   = CNT_ONE;
                state_nxt = S_RD;
              end
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        ram_req.we = 1'b1;
        if (is_ins_r) begin
          if (less) begin
            // The new value belongs just above the entry read.
            ram_req.wdata = val_r;
            count_nxt     = count_r + CNT_ONE;
            state_nxt     = S_DONE;
          end else begin
            ram_req.wdata = ram_rdata;
            idx_nxt       = idx_m1;
            state_nxt     = (idx_r == CNT_ONE) ? S_PUT : S_RD;
          end
        end else begin
          ram_req.waddr = idx_m1[ADDR_W-1:0];
          ram_req.wdata = ram_rdata;
          if (idx_r == CNT_ONE) begin
            head_nxt = ram_rdata;
          end
          idx_nxt = idx_p1;
          if (idx_p1 == count_r) begin
            count_nxt = count_r - CNT_ONE;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = '0;
        ram_req.wdata = val_r;
        head_nxt      = val_r;
        count_nxt     = count_r + CNT_ONE;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r       <= idx_nxt;
    head_r      <= head_nxt;
    val_r       <= val_nxt;
    is_ins_r    <= is_ins_nxt;
    popped_r    <= popped_nxt;
    pop_valid_r <= pop_valid_nxt;
    empty_err_r <= empty_err_nxt;
    full_drop_r <= full_drop_nxt;
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);

  always_comb begin
    result.popped_value = popped_r;
    result.pop_valid    = pop_valid_r;
    result.empty_error  = empty_err_r;
    result.full_drop    = full_drop_r;
    result.entry_count  = 5'(count_r);
    result.is_empty     = (count_r == '0);
    result.head_value   = (count_r == '0) ? '0 : head_r;
  end

  assign flag_clash   = pop_valid_r && (full_drop_r || empty_err_r);
  assign ins_shift    = (state_r == S_CMP) && is_ins_r;
  assign ins_count_ok = (count_r <= CNT_FULL) && (count_r != '0);

  `SPQ_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_FULL, "count beyond depth")
  `SPQ_ASSERT_NOW(a_ack_when_done, ack, state_r == S_DONE, "result taken while busy")
  `SPQ_ASSERT_NOW(a_flags_exclusive, state_r == S_DONE, !flag_clash, "conflicting result flags")
  `SPQ_ASSERT_NEXT(a_insert_room, ins_shift, ins_count_ok, "insert shift with bad count")

endmodule

`default_nettype wire

// ----- hdl/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Sorted list of signed Q16.16 values with insert, pop-smallest and query.
// ----------------------------------------------------------------------------
// Usage: an item on the in_ channel carries a mode and a value. Insert places
// the value in ascending order, pop removes the smallest value and query only
// reports. Each item yields exactly one result item on the out_ channel with
// the popped value, the flags, the count and the head value after the item.
// An item is taken at a clock edge where in_valid is high and in_stall is low.
// Operation: the entries live in a small RAM and are moved by a sequencer with
// one comparator, one entry per read-compare-write step (S_RD, then S_CMP).
// An insert moves each entry not smaller than the value up one place in such
// a step, and a value that lands at the bottom takes a further write step
// (S_PUT); a pop moves every remaining entry down one place. A query, a full
// drop, an empty pop or a pop of the last entry go straight to the done state.
// The next item is taken only once the sequencer has handed its result on
// and is idle again. The registered RAM read is why each step reads first.
// A new item is taken as soon as the sequencer is idle, even while the
// previous result still waits in the output register. When the receiver
// stalls, the finished result is held in the sequencer until the output
// register frees up. Reset empties the queue; the RAM is not cleared since
// only written entries are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue import spq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  logic                     seq_idle;
  logic                     seq_done;
  logic                     seq_start;
  logic                     seq_ack;
  out_item_t                seq_result;
  ram_req_t                 ram_req;
  logic signed [DATA_W-1:0] ram_rdata;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  // Input side: the sequencer takes an item whenever it is idle.
  assign in_stall  = !seq_idle;
  assign seq_start = in_valid && !in_stall;

  // The result moves into the output register once that register is free
  // or is being emptied in this very cycle.
  assign seq_ack = seq_done && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (seq_ack) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (seq_ack) begin
      out_item_r <= seq_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  spq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (seq_start),
    .item      (in_item),
    .ack       (seq_ack),
    .idle      (seq_idle),
    .done      (seq_done),
    .result    (seq_result),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  spq_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
